### design/spline_lut_interp_accumulator_macros.svh
// Assertion macros shared by the spline LUT interpolation accumulator RTL.
// Self-contained; the bodies compile away when SYNTHESIS is defined.
`ifndef SPLINE_LUT_INTERP_ACCUMULATOR_MACROS_SVH
`define SPLINE_LUT_INTERP_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SLIA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define SLIA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SLIA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLIA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### design/slia_pkg.sv
// Shared types and constants for the spline LUT interpolation accumulator.
// No dependencies.
`default_nettype none
package slia_pkg;
	localparam int TABLE_DEPTH = 2048;
	localparam int TABLE_AW    = 11;
	localparam int WORD_W      = 16;
	localparam int Q_W         = 32;
	localparam int ISW_W       = 31;
	localparam int FRAC_W      = 8;
	localparam int REG_IDX_W   = 2;

	localparam logic [REG_IDX_W-1:0] REG_DOMAIN_MIN = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DOMAIN_MAX = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_SEG_W  = 2'd2;

	localparam logic OP_TABLE_WRITE = 1'b0;
	localparam logic OP_SAMPLE      = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic tbl_wr;
		logic cap_sample;
		logic do_mul;
		logic do_idx;
		logic do_interp;
		logic do_acc;
	} slia_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_edge;
		logic out_busy;
	} slia_sts_t;
endpackage
`default_nettype wire

### design/slia_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module slia_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr_a,
	input  wire  [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule
`default_nettype wire

### design/slia_ctrl.sv
// Sequencer for the spline LUT interpolation accumulator.
// Depends on slia_pkg and spline_lut_interp_accumulator_macros.svh.
`default_nettype none
`include "spline_lut_interp_accumulator_macros.svh"
module slia_ctrl import slia_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        opcode,
	input  slia_sts_t  sts,
	output slia_cmd_t  cmd
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_IDX    = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_INTERP = 3'd4;
	localparam logic [2:0] ST_ACC    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.tbl_wr     = accept && (opcode == OP_TABLE_WRITE);
		cmd.cap_sample = accept && (opcode == OP_SAMPLE);
		cmd.do_mul     = (state_q == ST_MUL);
		cmd.do_idx     = (state_q == ST_IDX);
		cmd.do_interp  = (state_q == ST_INTERP);
		// the final edge waits until the output register is free
		cmd.do_acc     = (state_q == ST_ACC) && !(sts.last_edge && sts.out_busy);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.cap_sample) state_d = ST_MUL;
			end
			ST_MUL:    state_d = ST_IDX;
			ST_IDX:    state_d = ST_READ;
			ST_READ:   state_d = ST_INTERP;
			ST_INTERP: state_d = ST_ACC;
			ST_ACC: begin
				if (cmd.do_acc) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SLIA_ASSERT_NEXT(a_sample_starts, clk, arst_n, cmd.cap_sample, state_q == ST_MUL, "sample transfer did not start the sequence")
	`SLIA_ASSERT(a_no_result_overrun, clk, arst_n, cmd.do_acc && sts.last_edge |-> !sts.out_busy, "result overwrites an untaken result")
	`SLIA_ASSERT(a_one_command, clk, arst_n, $onehot0(cmd), "more than one datapath command at once")
endmodule
`default_nettype wire

### design/slia_dpath.sv
// Datapath: config registers, clip/scale/index stages, spline table, interpolation
// and saturating accumulator. Depends on slia_pkg and slia_ram.
`default_nettype none
module slia_dpath import slia_pkg::*; #(
	parameter int EDGES    = 16,
	parameter int SEGMENTS = 8,
	parameter int POINTS   = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [REG_IDX_W-1:0]        cfg_index,
	input  wire  [Q_W-1:0]              cfg_wdata,
	input  wire  [TABLE_AW-1:0]         table_address,
	input  wire  signed [WORD_W-1:0]    table_word,
	input  wire  signed [Q_W-1:0]       feature_value,
	input  slia_cmd_t                   cmd,
	output slia_sts_t                   sts,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic signed [Q_W-1:0]       logit,
	output logic                        class_bit
);
	localparam int EW   = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int SW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int PW   = $clog2(POINTS);
	localparam int TW   = 17;
	localparam int UW   = TW + PW;
	localparam int POSW = 2 * Q_W - 1 - 16;

	// configuration
	logic signed [Q_W-1:0]   dmin_q;
	logic signed [Q_W-1:0]   dmax_q;
	logic        [ISW_W-1:0] isw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q <= '0;
			dmax_q <= 32'sd65536;
			isw_q  <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DOMAIN_MIN: dmin_q <= cfg_wdata;
				REG_DOMAIN_MAX: dmax_q <= cfg_wdata;
				REG_INV_SEG_W:  isw_q  <= cfg_wdata[ISW_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: clip to [min, max - 1] and take the offset from min
	logic signed [Q_W:0]   lo_w;
	logic signed [Q_W:0]   hi_w;
	logic signed [Q_W:0]   xc_w;
	logic signed [Q_W+1:0] off_w;
	logic        [Q_W-1:0] off_s1;

	always_comb begin
		lo_w = {dmin_q[Q_W-1], dmin_q};
		hi_w = {dmax_q[Q_W-1], dmax_q} - 33'sd1;
		xc_w = {feature_value[Q_W-1], feature_value};
		if (xc_w < lo_w) xc_w = lo_w;
		if (xc_w > hi_w) xc_w = hi_w;
		off_w = {xc_w[Q_W], xc_w} - {lo_w[Q_W], lo_w};
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_sample) begin
			off_s1 <= off_w[Q_W+1] ? '0 : off_w[Q_W-1:0];
		end
	end

	// stage 2: scale by the inverse segment width
	logic [2*Q_W-2:0] prod_w;
	logic [POSW-1:0]  pos_s2;

	assign prod_w = (2*Q_W-1)'(off_s1) * (2*Q_W-1)'(isw_q);

	always_ff @(posedge clk) begin
		if (cmd.do_mul) begin
			pos_s2 <= prod_w[2*Q_W-2:16];
		end
	end

	// stage 3: segment, point, fraction and table address
	logic [EW-1:0]       edge_q;
	logic [POSW-17:0]    seg_hi_w;
	logic                seg_sat_w;
	logic [SW-1:0]       seg_w;
	logic [TW-1:0]       t_w;
	logic [UW-1:0]       u_w;
	logic [PW:0]         idx_raw_w;
	logic [PW-1:0]       idx_w;
	logic [31:0]         base_w;
	logic [TABLE_AW-1:0] addr_s3;
	logic [FRAC_W-1:0]   frac_s3;

	always_comb begin
		seg_hi_w  = pos_s2[POSW-1:16];
		seg_sat_w = seg_hi_w > (POSW-16)'(SEGMENTS - 1);
		// a saturated segment always leaves t at its ceiling of one
		seg_w     = seg_sat_w ? SW'(SEGMENTS - 1) : seg_hi_w[SW-1:0];
		t_w       = seg_sat_w ? 17'h10000 : {1'b0, pos_s2[15:0]};
		u_w       = UW'(t_w) * UW'(POINTS - 1);
		idx_raw_w = u_w[UW-1:16];
		idx_w     = (idx_raw_w > (PW+1)'(POINTS - 2)) ? PW'(POINTS - 2) : idx_raw_w[PW-1:0];
		base_w    = (32'(edge_q) * 32'(SEGMENTS) + 32'(seg_w)) * 32'(POINTS) + 32'(idx_w);
	end

	always_ff @(posedge clk) begin
		if (cmd.do_idx) begin
			addr_s3 <= base_w[TABLE_AW-1:0];
			frac_s3 <= u_w[15:8];
		end
	end

	// table: written on a table-word transfer, read at the point and its neighbor
	logic [WORD_W-1:0] v0_raw;
	logic [WORD_W-1:0] v1_raw;

	slia_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (cmd.tbl_wr),
		.waddr   (table_address),
		.wdata   (table_word),
		.raddr_a (addr_s3),
		.raddr_b (addr_s3 + TABLE_AW'(1)),
		.rdata_a (v0_raw),
		.rdata_b (v1_raw)
	);

	// stage 4: v0 + floor((v1 - v0) * frac / 256)
	logic signed [WORD_W-1:0] v0_w;
	logic signed [WORD_W-1:0] v1_w;
	logic signed [WORD_W:0]   diff_w;
	logic signed [FRAC_W:0]   frac_sx_w;
	logic signed [25:0]       iprod_w;
	logic signed [25:0]       ishift_w;
	logic signed [17:0]       step_w;
	logic signed [17:0]       contrib_s4;

	always_comb begin
		v0_w      = v0_raw;
		v1_w      = v1_raw;
		diff_w    = {v1_w[WORD_W-1], v1_w} - {v0_w[WORD_W-1], v0_w};
		frac_sx_w = {1'b0, frac_s3};
		iprod_w   = diff_w * frac_sx_w;
		ishift_w  = iprod_w >>> FRAC_W;
		step_w    = ishift_w[17:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.do_interp) begin
			contrib_s4 <= 18'(v0_w) + step_w;
		end
	end

	// stage 5: saturating accumulate, edge count and result register
	logic signed [Q_W-1:0] acc_q;
	logic signed [Q_W:0]   sum_w;
	logic signed [Q_W-1:0] sat_w;
	logic                  last_w;
	logic                  out_valid_q;
	logic signed [Q_W-1:0] logit_q;

	always_comb begin
		sum_w = {acc_q[Q_W-1], acc_q} + 33'(contrib_s4);
		if (sum_w[Q_W] != sum_w[Q_W-1]) begin
			sat_w = sum_w[Q_W] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			sat_w = sum_w[Q_W-1:0];
		end
	end

	assign last_w = (edge_q == EW'(EDGES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			edge_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_acc) begin
				if (last_w) begin
					acc_q  <= '0;
					edge_q <= '0;
				end else begin
					acc_q  <= sat_w;
					edge_q <= edge_q + EW'(1);
				end
			end
			if (cmd.do_acc && last_w) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_acc && last_w) begin
			logit_q <= sat_w;
		end
	end

	assign sts.last_edge = last_w;
	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign logit         = logit_q;
	assign class_bit     = ~logit_q[Q_W-1];
endmodule
`default_nettype wire

### design/spline_lut_interp_accumulator.sv
// Spline lookup-table interpolation accumulator, top level.
// Depends on slia_pkg, slia_ctrl, slia_dpath (and through it slia_ram).
//
// A table-word item is written straight into the 2048 x 16 spline table as
// it is taken. A feature sample holds the block, which takes no new input
// until the sample is done: the sequencer walks it through clip, 32x31 scale
// multiply, segment/point indexing, a two-port table read, interpolation and
// the saturating accumulate, in that order.
// After EDGES samples the logit and its class wait in an output register while
// new items are taken; only the last sample of the next group stalls in its
// accumulate step if that result has still not been transferred. Configuration
// writes take effect at once and are meant for an idle block.
`default_nettype none
module spline_lut_interp_accumulator import slia_pkg::*; #(
	parameter int EDGES    = 16,
	parameter int SEGMENTS = 8,
	parameter int POINTS   = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire  [REG_IDX_W-1:0]     cfg_index,
	input  wire  [Q_W-1:0]           cfg_wdata,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      opcode,
	input  wire  [TABLE_AW-1:0]      table_address,
	input  wire  signed [WORD_W-1:0] table_word,
	input  wire  signed [Q_W-1:0]    feature_value,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic signed [Q_W-1:0]    logit,
	output logic                     class_bit
);
	slia_cmd_t cmd;
	slia_sts_t sts;

	slia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	slia_dpath #(
		.EDGES    (EDGES),
		.SEGMENTS (SEGMENTS),
		.POINTS   (POINTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.table_address (table_address),
		.table_word    (table_word),
		.feature_value (feature_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.logit         (logit),
		.class_bit     (class_bit)
	);
endmodule
`default_nettype wire

### tb/tb_spline_lut_interp_accumulator.sv
// Self-checking testbench for spline_lut_interp_accumulator: table writes and Q16.16
// samples go in, and each logit/class result is checked against an in-bench predictor.
// Depends on slia_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_spline_lut_interp_accumulator;
	import slia_pkg::*;

	localparam int EDGES        = 16;
	localparam int SEGMENTS     = 8;
	localparam int POINTS       = 16;
	localparam int DRAIN_CYCLES = 16;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic [31:0] ISW_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic signed [31:0] logit;
		logic               class_bit;
	} logit_result_t;

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       cfg_we        = 1'b0;
	logic [REG_IDX_W-1:0]       cfg_index     = '0;
	logic [Q_W-1:0]             cfg_wdata     = '0;
	logic                       in_valid      = 1'b0;
	logic                       opcode        = OP_TABLE_WRITE;
	logic [TABLE_AW-1:0]        table_address = '0;
	logic signed [WORD_W-1:0]   table_word    = '0;
	logic signed [Q_W-1:0]      feature_value = '0;
	logic                       out_ready     = 1'b0;
	wire                        in_ready;
	wire                        out_valid;
	wire signed [Q_W-1:0]       logit;
	wire                        class_bit;

	// predictor state
	logic signed [15:0] spline_mem [TABLE_DEPTH];
	bit                 mem_written [TABLE_DEPTH];
	logic signed [31:0] logit_sum  = '0;
	int unsigned        edge_count = 0;
	logic signed [31:0] dom_min    = 32'sd0;
	logic signed [31:0] dom_max    = 32'sd65536;
	logic [30:0]        inv_seg_w  = 31'd65536;
	logit_result_t      pending_logits [$];

	int err_count  = 0;
	bit tx_free    = 1'b1;
	bit rx_free    = 1'b0;
	int burst_left = 0;
	int rx_run     = 0;
	bit rx_on      = 1'b1;

	spline_lut_interp_accumulator #(
		.EDGES(EDGES),
		.SEGMENTS(SEGMENTS),
		.POINTS(POINTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.table_address(table_address),
		.table_word(table_word),
		.feature_value(feature_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.logit(logit),
		.class_bit(class_bit)
	);

	initial forever #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_spline_lut_interp_accumulator: errors");
		$finish;
	end

	// receiver: alternating ready and stall runs unless rx_free is set
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_on = !rx_on;
			rx_run = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 20);
		end
		rx_run--;
		out_ready <= rx_free || rx_on;
	end

	always @(posedge clk) begin : check_results
		logit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_logits.size() == 0) begin
				$display("%0t: result with none expected: logit %0d class %0b",
					$time, logit, class_bit);
				err_count++;
			end else begin
				want = pending_logits.pop_front();
				if (logit !== want.logit) begin
					$display("%0t: logit expected %0d, got %0d", $time, want.logit, logit);
					err_count++;
				end
				if (class_bit !== want.class_bit) begin
					$display("%0t: class_bit expected %0b, got %0b",
						$time, want.class_bit, class_bit);
					err_count++;
				end
			end
		end
	end

	// clip, offset and scale a sample into its lower table address and fraction
	function automatic void locate_points(input logic signed [31:0] x,
			input int unsigned edge_idx, output logic [10:0] addr0, output int frac);
		longint lo, hi, xv, off;
		logic [63:0] pos, seg, t, u, idx, base;
		lo = dom_min;
		hi = longint'(dom_max) - 1;
		xv = x;
		if (xv < lo) xv = lo;
		if (xv > hi) xv = hi;
		off = xv - lo;
		if (off < 0) off = 0;
		pos = (64'(off) * 64'(inv_seg_w)) >> 16;
		seg = pos >> 16;
		if (seg > SEGMENTS - 1) seg = SEGMENTS - 1;
		t = pos - (seg << 16);
		if (t > 65536) t = 65536;
		u = t * (POINTS - 1);
		idx = u >> 16;
		if (idx > POINTS - 2) idx = POINTS - 2;
		frac = int'((u >> 8) & 64'hFF);
		base = (64'(edge_idx) * SEGMENTS + seg) * POINTS + idx;
		addr0 = base[10:0];
	endfunction

	function automatic int spline_contribution(input logic signed [31:0] x,
			input int unsigned edge_idx);
		logic [10:0] a0, a1;
		int frac, v0, v1;
		locate_points(x, edge_idx, a0, frac);
		a1 = a0 + 11'd1;
		v0 = spline_mem[a0];
		v1 = spline_mem[a1];
		// arithmetic shift floors toward minus infinity
		return v0 + (((v1 - v0) * frac) >>> 8);
	endfunction

	function automatic logic signed [15:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] matched_isw(input longint span);
		longint r;
		if (span <= 0) return ISW_MAX;
		r = ((longint'(SEGMENTS) << 32) + span / 2) / span;
		if (r > ISW_MAX) r = ISW_MAX;
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] pick_feature();
		longint lo, hi, v;
		lo = dom_min;
		hi = longint'(dom_max) - 1;
		case ($urandom_range(0, 9))
			0, 1: v = longint'($signed($urandom));
			2: v = lo + longint'($urandom_range(0, 4)) - 2;
			3: v = hi + longint'($urandom_range(0, 4)) - 2;
			default: begin
				if (hi < lo)
					v = longint'($signed($urandom));
				else
					v = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
			end
		endcase
		if (v > Q_MAX) v = Q_MAX;
		if (v < Q_MIN) v = Q_MIN;
		return v[31:0];
	endfunction

	task automatic send_item(input logic op, input logic [10:0] addr,
			input logic signed [15:0] word, input logic signed [31:0] x);
		longint s;
		if (!tx_free) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		table_address <= addr;
		table_word    <= word;
		feature_value <= x;
		do @(posedge clk); while (!in_ready);
		if (op == OP_TABLE_WRITE) begin
			spline_mem[addr] = word;
			mem_written[addr] = 1'b1;
		end else begin
			s = longint'(logit_sum) + spline_contribution(x, edge_count);
			if (s > Q_MAX) s = Q_MAX;
			if (s < Q_MIN) s = Q_MIN;
			logit_sum = s[31:0];
			edge_count++;
			if (edge_count == EDGES) begin
				pending_logits.push_back(logit_result_t'{logit_sum, logit_sum >= 0});
				logit_sum = '0;
				edge_count = 0;
			end
		end
	endtask

	// entries a sample will read are written first if they never were, or with zero when zero_fill is set
	task automatic send_sample(input logic signed [31:0] x, input bit zero_fill = 1'b0);
		logic [10:0] a0, a1;
		int frac;
		locate_points(x, edge_count, a0, frac);
		a1 = a0 + 11'd1;
		if (zero_fill || !mem_written[a0])
			send_item(OP_TABLE_WRITE, a0, zero_fill ? 16'sd0 : rand_word(), $urandom);
		if (zero_fill || !mem_written[a1])
			send_item(OP_TABLE_WRITE, a1, zero_fill ? 16'sd0 : rand_word(), $urandom);
		send_item(OP_SAMPLE, 11'($urandom), 16'($urandom), x);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_logits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_DOMAIN_MIN: dom_min = data;
			REG_DOMAIN_MAX: dom_max = data;
			REG_INV_SEG_W:  inv_seg_w = data[30:0];
			default: ;
		endcase
	endtask

	task automatic set_domain(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] isw);
		settle();
		write_reg(REG_DOMAIN_MIN, lo);
		write_reg(REG_DOMAIN_MAX, hi);
		write_reg(REG_INV_SEG_W, isw);
	endtask

	task automatic set_random_domain(input bit matched);
		longint lo, hi;
		lo = longint'($signed($urandom));
		hi = lo + (longint'($urandom_range(1, 255)) << $urandom_range(4, 24));
		if (hi > Q_MAX) hi = Q_MAX;
		set_domain(lo[31:0], hi[31:0], matched ? matched_isw(hi - lo) : $urandom);
	endtask

	task automatic run_mixed(input int n_items);
		int sent;
		sent = 0;
		tx_free = ($urandom_range(0, 3) == 0);
		rx_free = ($urandom_range(0, 3) == 0);
		while (sent < n_items) begin
			if ($urandom_range(0, 7) == 0)
				send_item(OP_TABLE_WRITE, 11'($urandom), rand_word(), $urandom);
			else
				send_sample(pick_feature());
			sent++;
		end
	endtask

	// aligned group over zeroed entries: logit is exactly zero, class must be 1
	task automatic run_zero_group();
		while (edge_count != 0) send_sample(pick_feature());
		repeat (EDGES) send_sample(pick_feature(), 1'b1);
	endtask

	task automatic test_table_extremes();
		send_item(OP_TABLE_WRITE, 11'd0, 16'sh8000, Q_MIN);
		send_item(OP_TABLE_WRITE, 11'h7FF, 16'sh7FFF, Q_MAX);
	endtask

	task automatic test_feature_extremes();
		logic signed [31:0] vals [EDGES] = '{Q_MIN, Q_MAX, 32'sd0, 32'sd1, -32'sd1,
			32'sd32768, 32'sd65535, 32'sd65536, 32'sd65537, 32'sd4096, 32'sd61440,
			32'sd255, 32'sd256, 32'sd65280, -32'sd65536, 32'sd12345};
		foreach (vals[i]) send_sample(vals[i]);
	endtask

	task automatic test_domain_corners();
		// inverted domain at the extremes, then an empty one
		set_domain(Q_MAX, Q_MIN, ISW_MAX);
		send_sample(Q_MIN);
		send_sample(Q_MAX);
		set_domain(32'sd5000, 32'sd5000, 32'd65536);
		send_sample(32'sd4999);
		send_sample(32'sd5001);
		// full range with the largest scale: segment and point saturate
		set_domain(Q_MIN, Q_MAX, ISW_MAX);
		send_sample(Q_MIN);
		send_sample(Q_MAX);
		send_sample(32'sd0);
		set_domain(-32'sd65536, 32'sd65536, 32'd0);
		send_sample(Q_MAX);
		send_sample(-32'sd1);
	endtask

	// each call of run_mixed also brings the table writes its samples need
	task automatic test_random();
		set_domain(32'sd0, 32'sd65536, 32'd65536);
		run_mixed(100);
		repeat (3) begin
			set_random_domain(1'b1);
			run_mixed(65);
		end
		run_zero_group();
		set_domain(Q_MIN, Q_MAX, matched_isw(longint'(Q_MAX) - longint'(Q_MIN)));
		run_mixed(65);
		set_domain($urandom, $urandom, {1'b1, 31'($urandom)});
		run_mixed(50);
		set_random_domain(1'b0);
		run_mixed(50);
		set_domain(-32'sd262144, 32'sd262144, ISW_MAX);
		run_mixed(50);
		set_domain(32'sd65536, -32'sd65536, $urandom);
		run_mixed(40);
		set_domain(Q_MIN, 32'sd0, 32'd0);
		run_zero_group();
		run_mixed(40);
		tx_free = 1'b1;
		rx_free = 1'b1;
		set_random_domain(1'b1);
		run_mixed(75);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_table_extremes();
		test_feature_extremes();
		test_domain_corners();
		test_random();
		settle();
		if (err_count == 0)
			$display("tb_spline_lut_interp_accumulator: clean");
		else
			$display("tb_spline_lut_interp_accumulator: errors");
		$finish;
	end
endmodule

### files.f
+incdir+design
design/slia_pkg.sv
design/slia_ram.sv
design/slia_ctrl.sv
design/slia_dpath.sv
design/spline_lut_interp_accumulator.sv
tb/tb_spline_lut_interp_accumulator.sv
